### rtl/lphs_pkg.sv
// Shared types and constants for the lift preset height sequencer.
package lphs_pkg;

  localparam int LVL_W  = 12;
  localparam int POS_W  = 24;
  localparam int JOG_W  = 16;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 3;
  localparam int CFG_W  = 24;

  localparam logic [LVL_W-1:0] THRESH_RST = 12'd2048;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  typedef enum logic [MODE_W-1:0] {
    MODE_HOME   = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_SCALE  = 2'd2,
    MODE_MANUAL = 2'd3
  } mode_t;

  typedef enum logic [ADDR_W-1:0] {
    CFG_THRESH = 3'd0,
    CFG_HOME   = 3'd1,
    CFG_SWITCH = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_JOG    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0]        thresh;
    logic signed [POS_W-1:0] home_h;
    logic signed [POS_W-1:0] switch_h;
    logic signed [POS_W-1:0] scale_h;
    logic [JOG_W-1:0]        jog;
  } cfg_t;

  // sequencing state carried from one tick to the next
  typedef struct packed {
    mode_t mode;
    logic  armed;
    logic  dn_was;
    logic  up_was;
  } seq_t;

endpackage

### rtl/lift_preset_height_sequencer.sv
// Top level of the lift preset height sequencer.
// One control tick is taken per request on in_*, and each tick gives exactly one
// result on out_*. A tick is registered on entry, then passes through one layer of
// compare and add logic into the result register once that register is free or its
// result is taken on out_tready; a new tick is accepted every cycle unless a stalled
// result blocks the path, and the input register can take the next tick while a
// result still waits on out_tready, as long as the input register is empty.
// Configuration writes on cfg_* take effect at once and belong in idle periods.
module lift_preset_height_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [11:0] down_level, [23:12] up_level, [47:24] lift_position
  input  logic [47:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [23:0] target_position, [25:24] mode_now, [31:26] zero
  output logic [31:0]                   out_tdata,
  input  logic                          cfg_we,
  input  logic [lphs_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [lphs_pkg::CFG_W-1:0]    cfg_wdata
);

  lphs_pkg::cfg_t cfg_r;

  logic                              in_v_r;
  logic [lphs_pkg::LVL_W-1:0]        dl_r;
  logic [lphs_pkg::LVL_W-1:0]        ul_r;
  logic signed [lphs_pkg::POS_W-1:0] pos_r;

  lphs_pkg::seq_t                    seq_r;
  lphs_pkg::seq_t                    seq_nxt;
  logic signed [lphs_pkg::POS_W-1:0] target_r;
  logic signed [lphs_pkg::POS_W-1:0] target_nxt;

  logic                              out_v_r;
  logic signed [lphs_pkg::POS_W-1:0] out_tgt_r;
  lphs_pkg::mode_t                   out_mode_r;

  logic advance;
  logic in_acc;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh   <= lphs_pkg::THRESH_RST;
      cfg_r.home_h   <= '0;
      cfg_r.switch_h <= '0;
      cfg_r.scale_h  <= '0;
      cfg_r.jog      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lphs_pkg::CFG_THRESH: cfg_r.thresh   <= cfg_wdata[lphs_pkg::LVL_W-1:0];
        lphs_pkg::CFG_HOME:   cfg_r.home_h   <= cfg_wdata[lphs_pkg::POS_W-1:0];
        lphs_pkg::CFG_SWITCH: cfg_r.switch_h <= cfg_wdata[lphs_pkg::POS_W-1:0];
        lphs_pkg::CFG_SCALE:  cfg_r.scale_h  <= cfg_wdata[lphs_pkg::POS_W-1:0];
        lphs_pkg::CFG_JOG:    cfg_r.jog      <= cfg_wdata[lphs_pkg::JOG_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r  <= in_tdata[11:0];
      ul_r  <= in_tdata[23:12];
      pos_r <= in_tdata[47:24];
    end
  end

  lphs_mode u_mode (
    .cfg           (cfg_r),
    .down_level    (dl_r),
    .up_level      (ul_r),
    .lift_position (pos_r),
    .seq_cur       (seq_r),
    .seq_next      (seq_nxt)
  );

  lphs_target u_target (
    .cfg           (cfg_r),
    .mode          (seq_nxt.mode),
    .dn            (seq_nxt.dn_was),
    .up            (seq_nxt.up_was),
    .lift_position (pos_r),
    .target_cur    (target_r),
    .target_next   (target_nxt)
  );

  // sequencing state moves only when a tick is committed to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.mode   <= lphs_pkg::MODE_HOME;
      seq_r.armed  <= 1'b0;
      seq_r.dn_was <= 1'b0;
      seq_r.up_was <= 1'b0;
      target_r     <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (advance) begin
        seq_r    <= seq_nxt;
        target_r <= target_nxt;
        out_v_r  <= 1'b1;
      end else if (out_tready) begin
        out_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tgt_r  <= target_nxt;
      out_mode_r <= seq_nxt.mode;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_mode_r, out_tgt_r};

endmodule

### rtl/lphs_mode.sv
// Trigger press detection and mode sequencing for one control tick.
module lphs_mode (
  input  lphs_pkg::cfg_t                    cfg,
  input  logic [lphs_pkg::LVL_W-1:0]        down_level,
  input  logic [lphs_pkg::LVL_W-1:0]        up_level,
  input  logic signed [lphs_pkg::POS_W-1:0] lift_position,
  input  lphs_pkg::seq_t                    seq_cur,
  output lphs_pkg::seq_t                    seq_next
);

  logic dn;
  logic up;

  assign dn = down_level > cfg.thresh;
  assign up = up_level > cfg.thresh;

  always_comb begin
    seq_next = seq_cur;
    seq_next.dn_was = dn;
    seq_next.up_was = up;

    // down release wins over a simultaneous up release
    if (!dn && seq_cur.dn_was) begin
      unique case (seq_cur.mode)
        lphs_pkg::MODE_SWITCH: seq_next.mode = lphs_pkg::MODE_HOME;
        lphs_pkg::MODE_SCALE:  seq_next.mode = lphs_pkg::MODE_SWITCH;
        lphs_pkg::MODE_MANUAL: begin
          if (seq_cur.armed) begin
            seq_next.mode  = lphs_pkg::MODE_SCALE;
            seq_next.armed = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (!up && seq_cur.up_was) begin
      unique case (seq_cur.mode)
        lphs_pkg::MODE_HOME:   seq_next.mode = lphs_pkg::MODE_SWITCH;
        lphs_pkg::MODE_SWITCH: seq_next.mode = lphs_pkg::MODE_SCALE;
        default: ;
      endcase
    end

    // arm the way back to scale only if down went in at or below scale height
    if (dn && !seq_cur.dn_was && seq_next.mode == lphs_pkg::MODE_MANUAL &&
        lift_position <= cfg.scale_h)
      seq_next.armed = 1'b1;

    if (up && seq_next.mode == lphs_pkg::MODE_SCALE && lift_position >= cfg.scale_h)
      seq_next.mode = lphs_pkg::MODE_MANUAL;
  end

endmodule

### rtl/lphs_target.sv
// Target selection: preset heights or saturating manual jog.
module lphs_target (
  input  lphs_pkg::cfg_t                    cfg,
  input  lphs_pkg::mode_t                   mode,
  input  logic                              dn,
  input  logic                              up,
  input  logic signed [lphs_pkg::POS_W-1:0] lift_position,
  input  logic signed [lphs_pkg::POS_W-1:0] target_cur,
  output logic signed [lphs_pkg::POS_W-1:0] target_next
);

  localparam int SUM_W = lphs_pkg::POS_W + 2;

  logic signed [SUM_W-1:0] tgt_ext;
  logic signed [SUM_W-1:0] jog_ext;
  logic signed [SUM_W-1:0] sum;
  logic                    jog_down;

  assign tgt_ext  = SUM_W'(target_cur);
  assign jog_ext  = $signed({{(SUM_W-lphs_pkg::JOG_W){1'b0}}, cfg.jog});
  assign jog_down = dn && (lift_position > cfg.scale_h);
  assign sum      = jog_down ? (tgt_ext - jog_ext) : (tgt_ext + jog_ext);

  always_comb begin
    unique case (mode)
      lphs_pkg::MODE_HOME:   target_next = cfg.home_h;
      lphs_pkg::MODE_SWITCH: target_next = cfg.switch_h;
      lphs_pkg::MODE_SCALE:  target_next = cfg.scale_h;
      default: begin
        if (jog_down || up) begin
          if (sum > SUM_W'(lphs_pkg::POS_MAX))
            target_next = lphs_pkg::POS_MAX;
          else if (sum < SUM_W'(lphs_pkg::POS_MIN))
            target_next = lphs_pkg::POS_MIN;
          else
            target_next = sum[lphs_pkg::POS_W-1:0];
        end else begin
          target_next = target_cur;
        end
      end
    endcase
  end

endmodule

### rtl/lphs_checker.sv
// Port-level checks for the lift preset height sequencer, bound to the top level.
module lphs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an accepted tick is followed by a valid result in the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted tick produced no result");

  // input back-pressure only comes from a full, stalled pipeline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

endmodule

bind lift_preset_height_sequencer lphs_checker u_lphs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/testbench.sv
// Self-checking testbench for the lift preset height sequencer, scoreboard included.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [lphs_pkg::ADDR_W-1:0] CFG_SPARE = 3'd7;

  typedef logic [lphs_pkg::LVL_W-1:0]        level_t;
  typedef logic signed [lphs_pkg::POS_W-1:0] pos_t;
  typedef logic [lphs_pkg::JOG_W-1:0]        jog_t;

  typedef struct {
    logic signed [lphs_pkg::POS_W-1:0] target;
    lphs_pkg::mode_t                   mode;
  } lift_cmd_t;

  class lift_scoreboard;
    logic [lphs_pkg::LVL_W-1:0]        thresh;
    logic signed [lphs_pkg::POS_W-1:0] home_h;
    logic signed [lphs_pkg::POS_W-1:0] switch_h;
    logic signed [lphs_pkg::POS_W-1:0] scale_h;
    logic [lphs_pkg::JOG_W-1:0]        jog;
    lphs_pkg::mode_t                   mode;
    bit                                dn_was;
    bit                                up_was;
    bit                                armed;
    logic signed [lphs_pkg::POS_W-1:0] target;
    lift_cmd_t                         cmd_q[$];
    int                                errors;
    int                                checked;
    int                                mode_hits[4];
    int                                sat_hits;

    function new();
      thresh   = lphs_pkg::THRESH_RST;
      home_h   = '0;
      switch_h = '0;
      scale_h  = '0;
      jog      = '0;
      mode     = lphs_pkg::MODE_HOME;
      dn_was   = 1'b0;
      up_was   = 1'b0;
      armed    = 1'b0;
      target   = '0;
      errors   = 0;
      checked  = 0;
      sat_hits = 0;
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void write_reg(input logic [lphs_pkg::ADDR_W-1:0] idx,
                            input logic [lphs_pkg::CFG_W-1:0] val);
      case (idx)
        lphs_pkg::CFG_THRESH: thresh = val[lphs_pkg::LVL_W-1:0];
        lphs_pkg::CFG_HOME:   home_h = val;
        lphs_pkg::CFG_SWITCH: switch_h = val;
        lphs_pkg::CFG_SCALE:  scale_h = val;
        lphs_pkg::CFG_JOG:    jog = val[lphs_pkg::JOG_W-1:0];
        default:    ;
      endcase
    endfunction

    // advance the sequencer by one accepted tick and queue its command
    function void note_tick(input logic [lphs_pkg::LVL_W-1:0] dl,
                            input logic [lphs_pkg::LVL_W-1:0] ul,
                            input logic signed [lphs_pkg::POS_W-1:0] pos);
      bit        dn;
      bit        up;
      longint    sum;
      lift_cmd_t cmd;
      dn = dl > thresh;
      up = ul > thresh;
      // a down release wins over a simultaneous up release
      if (!dn && dn_was) begin
        case (mode)
          lphs_pkg::MODE_SWITCH: mode = lphs_pkg::MODE_HOME;
          lphs_pkg::MODE_SCALE:  mode = lphs_pkg::MODE_SWITCH;
          lphs_pkg::MODE_MANUAL: begin
            if (armed) begin
              mode  = lphs_pkg::MODE_SCALE;
              armed = 1'b0;
            end
          end
          default: ;
        endcase
      end else if (!up && up_was) begin
        if (mode == lphs_pkg::MODE_HOME) mode = lphs_pkg::MODE_SWITCH;
        else if (mode == lphs_pkg::MODE_SWITCH) mode = lphs_pkg::MODE_SCALE;
      end
      if (dn && !dn_was && mode == lphs_pkg::MODE_MANUAL && pos <= scale_h) armed = 1'b1;
      if (up && mode == lphs_pkg::MODE_SCALE && pos >= scale_h) mode = lphs_pkg::MODE_MANUAL;
      case (mode)
        lphs_pkg::MODE_HOME:   target = home_h;
        lphs_pkg::MODE_SWITCH: target = switch_h;
        lphs_pkg::MODE_SCALE:  target = scale_h;
        default: begin
          sum = longint'(target);
          if (dn && pos > scale_h) sum = sum - longint'(jog);
          else if (up) sum = sum + longint'(jog);
          if (sum > longint'(lphs_pkg::POS_MAX)) begin
            sum = longint'(lphs_pkg::POS_MAX);
            sat_hits++;
          end else if (sum < longint'(lphs_pkg::POS_MIN)) begin
            sum = longint'(lphs_pkg::POS_MIN);
            sat_hits++;
          end
          target = sum[lphs_pkg::POS_W-1:0];
        end
      endcase
      dn_was = dn;
      up_was = up;
      mode_hits[mode]++;
      cmd.target = target;
      cmd.mode   = mode;
      cmd_q.push_back(cmd);
    endfunction

    task check_result(input logic [31:0] data);
      lift_cmd_t cmd;
      if (cmd_q.size() == 0) begin
        report($sformatf("result %h with no tick outstanding", data));
        return;
      end
      cmd = cmd_q.pop_front();
      checked++;
      if (data[lphs_pkg::POS_W-1:0] !== cmd.target)
        report($sformatf("target_position got %0d expected %0d",
                         $signed(data[lphs_pkg::POS_W-1:0]), cmd.target));
      if (data[lphs_pkg::POS_W+lphs_pkg::MODE_W-1:lphs_pkg::POS_W] !== cmd.mode)
        report($sformatf("mode_now got %0d expected %0d (%s)",
                         data[lphs_pkg::POS_W+lphs_pkg::MODE_W-1:lphs_pkg::POS_W],
                         cmd.mode, cmd.mode.name()));
      if (data[31:lphs_pkg::POS_W+lphs_pkg::MODE_W] !== '0)
        report($sformatf("padding bits not zero: %h", data));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [47:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [31:0]                   out_tdata;
  logic                          cfg_we = 1'b0;
  logic [lphs_pkg::ADDR_W-1:0]   cfg_addr = '0;
  logic [lphs_pkg::CFG_W-1:0]    cfg_wdata = '0;

  lift_scoreboard sb = new();
  int ticks_sent = 0;
  int settings_run = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  lift_preset_height_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // result side: check on handshake, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_tick(input logic [lphs_pkg::LVL_W-1:0] dl,
                           input logic [lphs_pkg::LVL_W-1:0] ul,
                           input logic signed [lphs_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pos, ul, dl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(dl, ul, pos);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [lphs_pkg::LVL_W-1:0] thr,
                           input logic [lphs_pkg::POS_W-1:0] home_v,
                           input logic [lphs_pkg::POS_W-1:0] switch_v,
                           input logic [lphs_pkg::POS_W-1:0] scale_v,
                           input logic [lphs_pkg::JOG_W-1:0] jog_v, input bit poke_spare);
    logic [lphs_pkg::ADDR_W-1:0] idxs[6];
    logic [lphs_pkg::CFG_W-1:0]  vals[6];
    int                          n;
    idxs = '{lphs_pkg::CFG_THRESH, lphs_pkg::CFG_HOME, lphs_pkg::CFG_SWITCH,
             lphs_pkg::CFG_SCALE, lphs_pkg::CFG_JOG, CFG_SPARE};
    vals = '{{12'd0, thr}, home_v, switch_v, scale_v, {8'd0, jog_v}, 24'hA5A5A5};
    n = poke_spare ? 6 : 5;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [lphs_pkg::LVL_W-1:0] level_on();
    if (sb.thresh == '1) return '1;
    return level_t'($urandom_range(4095, sb.thresh + 1));
  endfunction

  function automatic logic [lphs_pkg::LVL_W-1:0] level_off();
    return level_t'($urandom_range(sb.thresh, 0));
  endfunction

  function automatic logic signed [lphs_pkg::POS_W-1:0] clamp_pos(input longint p);
    if (p > longint'(lphs_pkg::POS_MAX)) return lphs_pkg::POS_MAX;
    if (p < longint'(lphs_pkg::POS_MIN)) return lphs_pkg::POS_MIN;
    return p[lphs_pkg::POS_W-1:0];
  endfunction

  // mostly near the scale boundary, since that is where the rules split
  function automatic logic signed [lphs_pkg::POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 40) return clamp_pos(longint'(sb.scale_h) + longint'($urandom_range(6)) - 3);
    if (r < 60) return sb.scale_h;
    if (r < 80) return pos_t'($urandom);
    if (r < 90) return lphs_pkg::POS_MAX;
    return lphs_pkg::POS_MIN;
  endfunction

  function automatic logic signed [lphs_pkg::POS_W-1:0] pos_at_or_above();
    return clamp_pos(longint'(sb.scale_h) + longint'($urandom_range(3)));
  endfunction

  task automatic run_gesture();
    int kind;
    int n;
    int pick;
    kind = $urandom_range(99);
    n    = $urandom_range(4, 1);
    if (kind < 15) begin
      // down press, hold, release
      repeat (n) send_tick(level_on(), level_off(), pick_pos());
      send_tick(level_off(), level_off(), pick_pos());
    end else if (kind < 28) begin
      repeat (n) send_tick(level_off(), level_on(), pick_pos());
      send_tick(level_off(), level_off(), pick_pos());
    end else if (kind < 48) begin
      // climb to scale and hold up at or above it to reach manual
      repeat (2) begin
        send_tick(level_off(), level_on(), pick_pos());
        send_tick(level_off(), level_off(), pick_pos());
      end
      repeat (n) send_tick(level_off(), level_on(), pos_at_or_above());
      send_tick(level_off(), level_off(), pick_pos());
    end else if (kind < 75) begin
      // jogging: down, up or both held with random releases in between
      repeat (n + 2) begin
        pick = $urandom_range(3);
        send_tick(pick[0] ? level_on() : level_off(), pick[1] ? level_on() : level_off(),
                  pick_pos());
      end
    end else if (kind < 85) begin
      repeat (n) send_tick(level_on(), level_on(), pick_pos());
      send_tick(level_off(), level_off(), pick_pos());
    end else begin
      repeat (n) send_tick(level_t'($urandom), level_t'($urandom), pos_t'($urandom));
    end
  endtask

  task automatic run_phase(input logic [lphs_pkg::LVL_W-1:0] thr,
                           input logic [lphs_pkg::POS_W-1:0] home_v,
                           input logic [lphs_pkg::POS_W-1:0] switch_v,
                           input logic [lphs_pkg::POS_W-1:0] scale_v,
                           input logic [lphs_pkg::JOG_W-1:0] jog_v, input int tx_pct,
                           input int rx_pct, input int n_ticks);
    int goal;
    wait_idle();
    apply_cfg(thr, home_v, switch_v, scale_v, jog_v, 1'b0);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    goal = ticks_sent + n_ticks;
    while (ticks_sent < goal) run_gesture();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk through every mode change and the boundary cases
    apply_cfg(12'd2048, -24'sd100, 24'sd5000, 24'sd8388000, 16'hFFFF, 1'b1);
    send_tick(12'd0, 12'd0, lphs_pkg::POS_MIN);
    send_tick(12'd0, 12'hFFF, 24'sd0);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'd0, 12'hFFF, 24'sd0);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'd0, 12'hFFF, lphs_pkg::POS_MAX);   // scale to manual, jog saturates high
    send_tick(12'd0, 12'hFFF, lphs_pkg::POS_MAX);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'hFFF, 12'd0, lphs_pkg::POS_MIN);   // arms the way back to scale
    send_tick(12'hFFF, 12'hFFF, 24'sd0);    // both held below scale: jogs up
    send_tick(12'd0, 12'd0, 24'sd0);        // both released: only down counts
    send_tick(12'd2048, 12'd0, 24'sd0);     // level equal to threshold is not pressed
    send_tick(12'd2049, 12'd0, 24'sd0);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'hFFF, 12'd0, lphs_pkg::POS_MAX);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'hFFF, 12'd0, 24'sd0);      // down at home stays home
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'd2048, 12'd2049, lphs_pkg::POS_MAX);
    send_tick(12'd0, 12'd2048, 24'sd0);
    send_tick(12'd0, 12'hFFF, 24'sd0);
    send_tick(12'd0, 12'd0, 24'sd0);
    send_tick(12'd0, 12'hFFF, lphs_pkg::POS_MAX);
    send_tick(12'hFFF, 12'd0, lphs_pkg::POS_MAX);   // above scale: jogs down
    send_tick(12'hFFF, 12'hFFF, lphs_pkg::POS_MAX); // both held above scale: down wins

    run_phase(12'd2048, 24'sd0, 24'sd1000, 24'sd2000, 16'd100, 0, 0, 140);
    run_phase(12'd0, lphs_pkg::POS_MIN, 24'sd0, -24'sd8388000, 16'hFFFF, 57, 0, 140);
    run_phase(12'd1, lphs_pkg::POS_MAX, -24'sd5, lphs_pkg::POS_MAX, 16'hFFFF, 0, 57, 140);
    run_phase(level_t'($urandom), pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
              jog_t'($urandom), 30, 30, 140);
    run_phase(12'hFFF, pos_t'($urandom), pos_t'($urandom), pos_t'($urandom), 16'd0,
              57, 57, 30);
    run_phase(level_t'($urandom_range(3000, 1000)), pos_t'($urandom), pos_t'($urandom),
              pos_t'($urandom), jog_t'($urandom), 0, 0, 120);

    // long output stall while input keeps coming: the block must backpressure
    wait_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 80;
    repeat (30) run_gesture();

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    $display("Sent %0d ticks over %0d register settings with mixed idling and a long hold-off;",
             ticks_sent, settings_run);
    $display("modes home/switch/scale/manual seen %0d/%0d/%0d/%0d, %0d saturated jogs.",
             sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3], sb.sat_hits);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
